// ===== src/decimal_seven_segment_digit_emitter_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the decimal seven segment digit emitter
// Expect clk and rst in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_SEVEN_SEGMENT_DIGIT_EMITTER_TOP_MACROS_SVH
`define DECIMAL_SEVEN_SEGMENT_DIGIT_EMITTER_TOP_MACROS_SVH

// Same-cycle implication
`define DSD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dsd assertion failed");

// Next-cycle implication
`define DSD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dsd assertion failed");

`endif

// ===== src/dsd_pkg.sv =====
// ----------------------------------------------------------------------------
// dsd_pkg
// Shared constants, command/status types and the segment table.
// ----------------------------------------------------------------------------
`default_nettype none

package dsd_pkg;

  localparam int MAX_DIGITS_DEF = 10;
  localparam int VALUE_BITS_DEF = 31;

  localparam int DIGIT_W = 4;
  localparam int SEG_W   = 7;
  localparam int POS_W   = 4;
  localparam int OUT_W   = 16;

  typedef struct packed {
    logic load;
    logic shift;
    logic skip;
    logic emit;
  } dsd_cmd_t;

  typedef struct packed {
    logic conv_last;
    logic lead_zero;
    logic last;
    logic out_free;
  } dsd_stat_t;

  // bit 6 upper left, 5 top, 4 upper right, 3 lower left, 2 middle,
  // 1 lower right, 0 bottom
  function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0: s = 7'b1111011;
      4'd1: s = 7'b0010010;
      4'd2: s = 7'b0111101;
      4'd3: s = 7'b0110111;
      4'd4: s = 7'b1010110;
      4'd5: s = 7'b1100111;
      4'd6: s = 7'b1101111;
      4'd7: s = 7'b0110010;
      4'd8: s = 7'b1111111;
      4'd9: s = 7'b1110111;
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== src/dsd_ctrl.sv =====
// ----------------------------------------------------------------------------
// dsd_ctrl
// Sequencer: accept, convert bit by bit, skip leading zeros, emit digits.
// ----------------------------------------------------------------------------
`default_nettype none
`include "decimal_seven_segment_digit_emitter_top_macros.svh"

module dsd_ctrl
  import dsd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      s_tvalid,
  output logic           s_tready,
  input  wire dsd_stat_t stat,
  output dsd_cmd_t       cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SKIP = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.shift = 1'b1;
        if (stat.conv_last) begin
          state_next = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (stat.lead_zero) begin
          cmd.skip = 1'b1;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `DSD_ASSERT_IMP(a_emit_slot_free, cmd.emit, stat.out_free)
  `DSD_ASSERT_NXT(a_conv_to_skip, (state == ST_CONV) && stat.conv_last, state == ST_SKIP)
  `DSD_ASSERT_NXT(a_last_to_idle, cmd.emit && stat.last, state == ST_IDLE)
  `DSD_ASSERT_IMP(a_no_skip_on_last, cmd.skip, !stat.last)

endmodule

`default_nettype wire

// ===== src/dsd_datapath.sv =====
// ----------------------------------------------------------------------------
// dsd_datapath
// Shift-and-add-3 binary to BCD converter, digit pointer and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dsd_datapath
  import dsd_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [VALUE_BITS-1:0] value,
  input  wire dsd_cmd_t              cmd,
  output dsd_stat_t                  stat,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [DIGIT_W-1:0]         digit_value,
  output logic [SEG_W-1:0]           segment_pattern,
  output logic [POS_W-1:0]           digit_position,
  output logic                       last_digit
);

  localparam int BCD_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int BCD_W      = BCD_DIGITS * DIGIT_W;
  localparam int IDX_W      = (BCD_DIGITS > 1) ? $clog2(BCD_DIGITS) : 1;
  localparam int TOP_IDX    = ((MAX_DIGITS < BCD_DIGITS) ? MAX_DIGITS : BCD_DIGITS) - 1;
  localparam int CNT_W      = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0] val;
  logic [BCD_W-1:0]      bcd;
  logic [BCD_W-1:0]      bcd_adj;
  logic [CNT_W-1:0]      cnt;
  logic [IDX_W-1:0]      idx;
  logic [POS_W-1:0]      pos;
  logic [DIGIT_W-1:0]    cur_digit;
  logic                  high_nz;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W] + 4'd3;
      end else begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  // digits above the display window are dropped; if any is nonzero, the
  // window shows all its positions, zeros included
  always_comb begin
    high_nz = 1'b0;
    for (int i = TOP_IDX + 1; i < BCD_DIGITS; i++) begin
      high_nz = high_nz | (bcd[i*DIGIT_W +: DIGIT_W] != '0);
    end
  end

  assign cur_digit = bcd[idx*DIGIT_W +: DIGIT_W];

  assign stat.conv_last = (cnt == CNT_W'(1));
  assign stat.last      = (idx == '0);
  assign stat.lead_zero = !high_nz && (idx != '0) && (cur_digit == '0);
  assign stat.out_free  = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val <= value;
      bcd <= '0;
      cnt <= CNT_W'(VALUE_BITS);
      idx <= IDX_W'(TOP_IDX);
      pos <= '0;
    end else if (cmd.shift) begin
      bcd <= {bcd_adj[BCD_W-2:0], val[VALUE_BITS-1]};
      val <= {val[VALUE_BITS-2:0], 1'b0};
      cnt <= cnt - CNT_W'(1);
    end else if (cmd.skip) begin
      idx <= idx - IDX_W'(1);
    end else if (cmd.emit) begin
      idx <= idx - IDX_W'(1);
      pos <= pos + POS_W'(1);
    end
  end

  // output register, payload loads on emit
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      digit_value     <= cur_digit;
      segment_pattern <= seg_of(cur_digit);
      digit_position  <= pos;
      last_digit      <= (idx == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== src/decimal_seven_segment_digit_emitter_top.sv =====
// ----------------------------------------------------------------------------
// decimal_seven_segment_digit_emitter_top
// Binary to decimal digits, most significant first, with segment patterns.
//
//   port group   dir  payload
//   s_t*         in   value (one transaction per number)
//   m_t*         out  one digit per transaction, tlast on the last digit
//
// An item takes VALUE_BITS steps of shift-and-add-3 conversion, then one
// step per display position from min(MAX_DIGITS, BCD size) down to the
// last digit (leading zeros skipped, digits emitted), plus the accept and
// skip-to-emit sequencing steps. Reset clears the sequencer and the output
// valid. A stalled output holds digit emission; the next value is taken once
// the last digit is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module decimal_seven_segment_digit_emitter_top
  import dsd_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [((VALUE_BITS+7)/8)*8-1:0]   s_tdata,  // value
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // digit_value, segment_pattern, digit_position
  output logic [OUT_W-1:0]                       m_tdata,
  output logic                                   m_tlast   // last_digit
);

  dsd_cmd_t            cmd;
  dsd_stat_t           stat;
  logic [DIGIT_W-1:0]  digit_value;
  logic [SEG_W-1:0]    segment_pattern;
  logic [POS_W-1:0]    digit_position;

  dsd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dsd_datapath #(
    .MAX_DIGITS (MAX_DIGITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .value           (s_tdata[VALUE_BITS-1:0]),
    .cmd             (cmd),
    .stat            (stat),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .digit_value     (digit_value),
    .segment_pattern (segment_pattern),
    .digit_position  (digit_position),
    .last_digit      (m_tlast)
  );

  assign m_tdata = {1'b0, digit_position, segment_pattern, digit_value};

endmodule

`default_nettype wire
